[hdl/whcc_pkg.sv]
package whcc_pkg;

	typedef enum logic [1:0] {
		OP_MUL  = 2'd0,
		OP_DIV  = 2'd1,
		OP_SQRT = 2'd2
	} arith_op_t;

	typedef struct packed {
		logic      start;
		arith_op_t op;
		logic      rnd;
	} arith_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} arith_sts_t;

	localparam int MUL_STEPS  = 32;
	localparam int DIV_STEPS  = 64;
	localparam int SQRT_STEPS = 32;

	localparam logic [1:0] PAIR_A [6] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1};
	localparam logic [1:0] PAIR_B [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

	localparam logic [15:0] FALLBACK_RESET = 16'd102;

	localparam logic signed [63:0] COV_MAX = 64'sd549755813887;
	localparam logic signed [63:0] COV_MIN = -64'sd549755813888;
	localparam logic signed [63:0] CEN_MAX = 64'sd536805376;
	localparam logic signed [63:0] CEN_MIN = -64'sd536870912;
	localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] I32_MIN = -64'sd2147483648;
	localparam logic signed [63:0] I16_MAX = 64'sd32767;
	localparam logic signed [63:0] I16_MIN = -64'sd32768;
	localparam logic signed [63:0] I14_MAX = 64'sd8191;
	localparam logic signed [63:0] I14_MIN = -64'sd8192;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
			input logic signed [63:0] lo, input logic signed [63:0] hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Divide by a power of two, rounding to nearest with ties away from zero.
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
			input int unsigned sh);
		logic [63:0] m;
		m = mag64(v) + (64'd1 << (sh - 1));
		m = m >> sh;
		return v[63] ? -$signed(m) : $signed(m);
	endfunction

endpackage

[hdl/weighted_hit_centroid_covariance.sv]
// Charge-weighted hit cluster summary. Each hit transferred on the input channel is added to
// the current cluster, and one result with the running centroid, deviations, covariance, charge
// sum, weighted path coordinate and hit count is transferred on the output channel. Most of the
// arithmetic runs through one shared unit that multiplies, divides or takes a square root, one
// bit per cycle, under a sequencer. The first hit of a cluster seeds the centroid and covariance;
// most of the work for a later hit lies in the six covariance updates of three multiplications
// and two divisions each. The input is not ready while a hit is being worked on; a finished
// result waits in the output register while the next hit is taken.
module weighted_hit_centroid_covariance #(
	parameter int MAX_HITS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               start_cluster,
	input  logic [15:0]        charge,
	input  logic signed [13:0] pos_x,
	input  logic signed [13:0] pos_y,
	input  logic signed [13:0] pos_z,
	input  logic signed [15:0] path_coord,
	input  logic [11:0]        res_x,
	input  logic [11:0]        res_y,
	input  logic [11:0]        res_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [13:0] center_x,
	output logic signed [13:0] center_y,
	output logic signed [13:0] center_z,
	output logic [15:0]        dev_x,
	output logic [15:0]        dev_y,
	output logic [15:0]        dev_z,
	output logic signed [31:0] cov_xy,
	output logic signed [31:0] cov_xz,
	output logic signed [31:0] cov_yz,
	output logic [21:0]        total_charge,
	output logic signed [15:0] mean_path,
	output logic [6:0]         hit_count,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata
);

	localparam int HW = $clog2(MAX_HITS + 1);

	typedef enum logic [20:0] {
		ST_IDLE  = 21'd1 << 0,
		ST_PREP  = 21'd1 << 1,
		ST_PM_A  = 21'd1 << 2,
		ST_PM_B  = 21'd1 << 3,
		ST_PM_C  = 21'd1 << 4,
		ST_SEED  = 21'd1 << 5,
		ST_CEN_A = 21'd1 << 6,
		ST_CEN_B = 21'd1 << 7,
		ST_EDIFF = 21'd1 << 8,
		ST_CV_A  = 21'd1 << 9,
		ST_CV_B  = 21'd1 << 10,
		ST_CV_C  = 21'd1 << 11,
		ST_CV_D  = 21'd1 << 12,
		ST_CV_E  = 21'd1 << 13,
		ST_CV_W  = 21'd1 << 14,
		ST_FALL  = 21'd1 << 15,
		ST_NF_A  = 21'd1 << 16,
		ST_NF_B  = 21'd1 << 17,
		ST_DV_A  = 21'd1 << 18,
		ST_DV_B  = 21'd1 << 19,
		ST_RES   = 21'd1 << 20
	} state_t;

	function automatic logic signed [31:0] fix16(input logic signed [13:0] v);
		return {{2{v[13]}}, v, 16'd0};
	endfunction

	state_t             state_q;
	logic               wait_q;
	logic [2:0]         k_q;
	logic [15:0]        q_q;
	logic signed [13:0] h_q [3];
	logic signed [15:0] s_q;
	logic [11:0]        r_q [3];
	logic signed [31:0] cen_q [3];
	logic signed [39:0] cov_q [6];
	logic [22:0]        csum_q;
	logic [37:0]        csq_q;
	logic signed [31:0] pm_q;
	logic [HW-1:0]      hits_q;
	logic [HW-1:0]      n_q;
	logic signed [31:0] e_q [3];
	logic signed [63:0] acc_q;
	logic signed [63:0] first_q;
	logic [46:0]        neff_q;
	logic [15:0]        dev_q [3];
	logic [15:0]        fb_q;

	logic [31:0]        q_sq;
	logic [23:0]        csum_add;
	logic [22:0]        q1_c;
	logic [38:0]        csq_add;
	logic [37:0]        qq1_c;
	logic [1:0]         k1;
	logic signed [31:0] diff_c;
	logic signed [39:0] cov_k;
	logic signed [63:0] v_c;
	state_t             after_pm;

	whcc_pkg::arith_req_t u_req;
	whcc_pkg::arith_sts_t u_sts;
	logic signed [63:0]   u_a;
	logic signed [63:0]   u_b;
	logic signed [63:0]   u_res;

	always_comb begin
		q_sq     = 32'(q_q) * 32'(q_q);
		csum_add = {1'b0, csum_q} + 24'(q_q);
		q1_c     = csum_add[23] ? '1 : csum_add[22:0];
		csq_add  = {1'b0, csq_q} + 39'(q_sq);
		qq1_c    = csq_add[38] ? '1 : csq_add[37:0];
		k1       = k_q[1:0];
		diff_c   = fix16(h_q[k1]) - cen_q[k1];
		cov_k    = cov_q[k_q];
		v_c      = cov_k[39] ? 64'sd0 : 64'(cov_k);
		if (hits_q == '0) begin
			after_pm = ST_SEED;
		end else if (q1_c != '0) begin
			after_pm = ST_CEN_A;
		end else begin
			after_pm = ST_EDIFF;
		end
	end

	always_comb begin
		u_req.start = 1'b0;
		u_req.op    = whcc_pkg::OP_MUL;
		u_req.rnd   = 1'b1;
		u_a         = '0;
		u_b         = '0;
		unique case (state_q)
			ST_PM_A: begin
				u_req.start = 1'b1;
				u_a = 64'(pm_q);
				u_b = $signed(64'(csum_q));
			end
			ST_PM_B: begin
				u_req.start = 1'b1;
				u_a = $signed({{32{s_q[15]}}, s_q, 16'd0});
				u_b = $signed(64'(q_q));
			end
			ST_PM_C, ST_CEN_B, ST_CV_B: begin
				u_req.start = 1'b1;
				u_req.op    = whcc_pkg::OP_DIV;
				u_a = acc_q;
				u_b = $signed(64'(q1_c));
			end
			ST_CEN_A: begin
				u_req.start = 1'b1;
				u_a = 64'(diff_c);
				u_b = $signed(64'(q_q));
			end
			ST_CV_A: begin
				u_req.start = q1_c != '0;
				u_a = 64'(cov_k);
				u_b = $signed(64'(csum_q));
			end
			ST_CV_C: begin
				u_req.start = csum_q != '0;
				u_a = 64'(e_q[whcc_pkg::PAIR_A[k_q]]);
				u_b = 64'(e_q[whcc_pkg::PAIR_B[k_q]]);
			end
			ST_CV_D: begin
				u_req.start = 1'b1;
				u_a = whcc_pkg::rnd_shr(acc_q, 24);
				u_b = $signed(64'(q_q));
			end
			ST_CV_E: begin
				u_req.start = 1'b1;
				u_req.op    = whcc_pkg::OP_DIV;
				u_a = acc_q;
				u_b = $signed(64'(csum_q));
			end
			ST_NF_A: begin
				u_req.start = 1'b1;
				u_a = $signed(64'(csum_q));
				u_b = $signed(64'(csum_q));
			end
			ST_NF_B: begin
				u_req.start = 1'b1;
				u_req.op    = whcc_pkg::OP_DIV;
				u_req.rnd   = 1'b0;
				u_a = acc_q;
				u_b = $signed(64'(csq_q));
			end
			ST_DV_A: begin
				u_req.start = n_q > HW'(1);
				u_req.op    = whcc_pkg::OP_DIV;
				u_req.rnd   = 1'b0;
				u_a = v_c;
				u_b = $signed(64'(neff_q));
			end
			ST_DV_B: begin
				u_req.start = 1'b1;
				u_req.op    = whcc_pkg::OP_SQRT;
				u_a = acc_q;
			end
			default: begin
				u_req.start = 1'b0;
			end
		endcase
		if (wait_q) begin
			u_req.start = 1'b0;
		end
	end

	whcc_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (u_req),
		.a      (u_a),
		.b      (u_b),
		.sts    (u_sts),
		.res    (u_res)
	);

	assign in_ready = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wait_q    <= 1'b0;
			k_q       <= '0;
			for (int i = 0; i < 3; i++) begin
				cen_q[i] <= '0;
			end
			for (int i = 0; i < 6; i++) begin
				cov_q[i] <= '0;
			end
			csum_q    <= '0;
			csq_q     <= '0;
			pm_q      <= '0;
			hits_q    <= '0;
			fb_q      <= whcc_pkg::FALLBACK_RESET;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				fb_q <= cfg_wdata;
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (u_req.start) begin
				wait_q <= 1'b1;
			end
			if (u_sts.done) begin
				wait_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						q_q    <= charge;
						h_q[0] <= pos_x;
						h_q[1] <= pos_y;
						h_q[2] <= pos_z;
						s_q    <= path_coord;
						r_q[0] <= res_x;
						r_q[1] <= res_y;
						r_q[2] <= res_z;
						if (start_cluster) begin
							for (int i = 0; i < 3; i++) begin
								cen_q[i] <= '0;
							end
							for (int i = 0; i < 6; i++) begin
								cov_q[i] <= '0;
							end
							csum_q <= '0;
							csq_q  <= '0;
							pm_q   <= '0;
							hits_q <= '0;
						end
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					n_q     <= hits_q;
					k_q     <= '0;
					state_q <= (q1_c != '0) ? ST_PM_A : after_pm;
				end
				ST_PM_A: begin
					if (u_sts.done) begin
						acc_q   <= u_res;
						state_q <= ST_PM_B;
					end
				end
				ST_PM_B: begin
					if (u_sts.done) begin
						acc_q   <= acc_q + u_res;
						state_q <= ST_PM_C;
					end
				end
				ST_PM_C: begin
					if (u_sts.done) begin
						pm_q    <= 32'(whcc_pkg::clamp64(u_res, whcc_pkg::I32_MIN,
							whcc_pkg::I32_MAX));
						state_q <= after_pm;
					end
				end
				ST_SEED: begin
					for (int i = 0; i < 3; i++) begin
						cen_q[i] <= fix16(h_q[i]);
						cov_q[i] <= $signed(40'(24'(r_q[i]) * 24'(r_q[i])));
					end
					state_q <= ST_FALL;
				end
				ST_CEN_A: begin
					if (u_sts.done) begin
						acc_q   <= u_res;
						state_q <= ST_CEN_B;
					end
				end
				ST_CEN_B: begin
					if (u_sts.done) begin
						cen_q[k1] <= 32'(whcc_pkg::clamp64(64'(cen_q[k1]) + u_res,
							whcc_pkg::CEN_MIN, whcc_pkg::CEN_MAX));
						if (k_q == 3'd2) begin
							k_q     <= '0;
							state_q <= ST_EDIFF;
						end else begin
							k_q     <= k_q + 3'd1;
							state_q <= ST_CEN_A;
						end
					end
				end
				ST_EDIFF: begin
					for (int i = 0; i < 3; i++) begin
						e_q[i] <= fix16(h_q[i]) - cen_q[i];
						if (n_q == HW'(1)) begin
							cov_q[i] <= '0;
						end
					end
					k_q     <= '0;
					state_q <= ST_CV_A;
				end
				ST_CV_A: begin
					if (q1_c == '0) begin
						first_q <= 64'(cov_k);
						state_q <= ST_CV_C;
					end else if (u_sts.done) begin
						acc_q   <= u_res;
						state_q <= ST_CV_B;
					end
				end
				ST_CV_B: begin
					if (u_sts.done) begin
						first_q <= u_res;
						state_q <= ST_CV_C;
					end
				end
				ST_CV_C: begin
					if (csum_q == '0) begin
						acc_q   <= '0;
						state_q <= ST_CV_W;
					end else if (u_sts.done) begin
						acc_q   <= u_res;
						state_q <= ST_CV_D;
					end
				end
				ST_CV_D: begin
					if (u_sts.done) begin
						acc_q   <= u_res;
						state_q <= ST_CV_E;
					end
				end
				ST_CV_E: begin
					if (u_sts.done) begin
						acc_q   <= u_res;
						state_q <= ST_CV_W;
					end
				end
				ST_CV_W: begin
					cov_q[k_q] <= 40'(whcc_pkg::clamp64(first_q + acc_q, whcc_pkg::COV_MIN,
						whcc_pkg::COV_MAX));
					if (k_q == 3'd5) begin
						state_q <= ST_FALL;
					end else begin
						k_q     <= k_q + 3'd1;
						state_q <= ST_CV_A;
					end
				end
				ST_FALL: begin
					if (cov_q[0] == '0 || cov_q[2] == '0) begin
						cov_q[0] <= $signed({16'd0, fb_q, 8'd0});
						cov_q[2] <= $signed({16'd0, fb_q, 8'd0});
					end
					csum_q <= q1_c;
					csq_q  <= qq1_c;
					if (hits_q < HW'(MAX_HITS)) begin
						hits_q <= hits_q + HW'(1);
					end
					k_q <= '0;
					if (qq1_c != '0) begin
						state_q <= ST_NF_A;
					end else begin
						neff_q  <= 47'd1;
						state_q <= ST_DV_A;
					end
				end
				ST_NF_A: begin
					if (u_sts.done) begin
						acc_q   <= u_res;
						state_q <= ST_NF_B;
					end
				end
				ST_NF_B: begin
					if (u_sts.done) begin
						neff_q  <= (u_res == '0) ? 47'd1 : 47'(u_res);
						state_q <= ST_DV_A;
					end
				end
				ST_DV_A: begin
					if (!(n_q > HW'(1))) begin
						acc_q   <= v_c;
						state_q <= ST_DV_B;
					end else if (u_sts.done) begin
						acc_q   <= u_res;
						state_q <= ST_DV_B;
					end
				end
				ST_DV_B: begin
					if (u_sts.done) begin
						dev_q[k1] <= (u_res > 64'sd65535) ? 16'hFFFF : 16'(u_res);
						if (k_q == 3'd2) begin
							state_q <= ST_RES;
						end else begin
							k_q     <= k_q + 3'd1;
							state_q <= ST_DV_A;
						end
					end
				end
				ST_RES: begin
					if (!out_valid || out_ready) begin
						center_x <= 14'(whcc_pkg::clamp64(whcc_pkg::rnd_shr(64'(cen_q[0]), 16),
							whcc_pkg::I14_MIN, whcc_pkg::I14_MAX));
						center_y <= 14'(whcc_pkg::clamp64(whcc_pkg::rnd_shr(64'(cen_q[1]), 16),
							whcc_pkg::I14_MIN, whcc_pkg::I14_MAX));
						center_z <= 14'(whcc_pkg::clamp64(whcc_pkg::rnd_shr(64'(cen_q[2]), 16),
							whcc_pkg::I14_MIN, whcc_pkg::I14_MAX));
						dev_x    <= dev_q[0];
						dev_y    <= dev_q[1];
						dev_z    <= dev_q[2];
						cov_xy   <= 32'(whcc_pkg::clamp64(whcc_pkg::rnd_shr(64'(cov_q[3]), 8),
							whcc_pkg::I32_MIN, whcc_pkg::I32_MAX));
						cov_xz   <= 32'(whcc_pkg::clamp64(whcc_pkg::rnd_shr(64'(cov_q[4]), 8),
							whcc_pkg::I32_MIN, whcc_pkg::I32_MAX));
						cov_yz   <= 32'(whcc_pkg::clamp64(whcc_pkg::rnd_shr(64'(cov_q[5]), 8),
							whcc_pkg::I32_MIN, whcc_pkg::I32_MAX));
						total_charge <= csum_q[22] ? 22'h3FFFFF : csum_q[21:0];
						mean_path <= 16'(whcc_pkg::clamp64(whcc_pkg::rnd_shr(64'(pm_q), 16),
							whcc_pkg::I16_MIN, whcc_pkg::I16_MAX));
						hit_count <= (32'(hits_q) > 32'd127) ? 7'd127 : 7'(hits_q);
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		u_req.start |-> !u_sts.busy)
		else $error("Arithmetic unit started while busy.");

	a_hits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hits_q <= HW'(MAX_HITS))
		else $error("Hit count beyond its maximum.");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RES && out_valid && !out_ready) |=> state_q == ST_RES)
		else $error("Result overwritten before its transfer.");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("Sequencer state is not one-hot.");

endmodule

[hdl/whcc_arith.sv]
module whcc_arith (
	input  logic                    clk,
	input  logic                    arst_n,
	input  whcc_pkg::arith_req_t    req,
	input  logic signed [63:0]      a,
	input  logic signed [63:0]      b,
	output whcc_pkg::arith_sts_t    sts,
	output logic signed [63:0]      res
);

	logic                busy_q;
	logic                done_q;
	logic [6:0]          cnt_q;
	whcc_pkg::arith_op_t op_q;
	logic                neg_q;
	logic [63:0]         x_q;
	logic [63:0]         y_q;
	logic [64:0]         z_q;

	logic [63:0] a_mag;
	logic [63:0] b_mag;
	logic [64:0] mul_z;
	logic [64:0] rem_sh;
	logic        div_ge;
	logic [64:0] div_z;
	logic [63:0] sq_t;
	logic        sq_ge;

	always_comb begin
		a_mag  = whcc_pkg::mag64(a);
		b_mag  = whcc_pkg::mag64(b);
		mul_z  = y_q[0] ? z_q + {1'b0, x_q} : z_q;
		rem_sh = {z_q[63:0], x_q[63]};
		div_ge = rem_sh >= {1'b0, y_q};
		div_z  = div_ge ? rem_sh - {1'b0, y_q} : rem_sh;
		sq_t   = z_q[63:0] + y_q;
		sq_ge  = x_q >= sq_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				unique case (req.op)
					whcc_pkg::OP_MUL:  cnt_q <= 7'(whcc_pkg::MUL_STEPS);
					whcc_pkg::OP_DIV:  cnt_q <= 7'(whcc_pkg::DIV_STEPS);
					whcc_pkg::OP_SQRT: cnt_q <= 7'(whcc_pkg::SQRT_STEPS);
					default:           cnt_q <= 7'd1;
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q <= req.op;
			z_q  <= '0;
			unique case (req.op)
				whcc_pkg::OP_MUL: begin
					x_q   <= a_mag;
					y_q   <= {32'd0, b_mag[31:0]};
					neg_q <= a[63] ^ b[63];
				end
				whcc_pkg::OP_DIV: begin
					x_q   <= a_mag + (req.rnd ? {1'b0, b_mag[63:1]} : 64'd0);
					y_q   <= b_mag;
					neg_q <= a[63];
				end
				whcc_pkg::OP_SQRT: begin
					x_q   <= 64'(a);
					y_q   <= 64'd1 << 62;
					neg_q <= 1'b0;
				end
				default: begin
					x_q   <= '0;
					y_q   <= '0;
					neg_q <= 1'b0;
				end
			endcase
		end else if (busy_q) begin
			unique case (op_q)
				whcc_pkg::OP_MUL: begin
					z_q <= mul_z;
					x_q <= x_q << 1;
					y_q <= y_q >> 1;
				end
				whcc_pkg::OP_DIV: begin
					z_q <= div_z;
					x_q <= {x_q[62:0], div_ge};
				end
				whcc_pkg::OP_SQRT: begin
					if (sq_ge) begin
						x_q <= x_q - sq_t;
						z_q <= {1'b0, (z_q[63:0] >> 1) + y_q};
					end else begin
						z_q <= z_q >> 1;
					end
					y_q <= y_q >> 2;
				end
				default: begin
					z_q <= z_q;
				end
			endcase
		end
	end

	always_comb begin
		unique case (op_q)
			whcc_pkg::OP_MUL:  res = neg_q ? -$signed(z_q[63:0]) : $signed(z_q[63:0]);
			whcc_pkg::OP_DIV:  res = neg_q ? -$signed(x_q) : $signed(x_q);
			whcc_pkg::OP_SQRT: res = $signed(z_q[63:0]);
			default:           res = '0;
		endcase
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule
